// ===== rtl/rcdb_pkg.sv =====
// Shared types and constants of the rotation-curve distance binner.
package rcdb_pkg;

    // Action code of one request.
    typedef logic [1:0] t_action;

    localparam t_action ACT_LOAD   = 2'd0;
    localparam t_action ACT_SAMPLE = 2'd1;
    localparam t_action ACT_READ   = 2'd2;

    // Configuration register indexes.
    localparam logic [3:0] CFG_MIN_LEVEL     = 4'd0;
    localparam logic [3:0] CFG_VEL_AT_COL0   = 4'd1;
    localparam logic [3:0] CFG_VEL_STEP      = 4'd2;
    localparam logic [3:0] CFG_SUN_TERM_SIN  = 4'd3;
    localparam logic [3:0] CFG_SUN_TERM_COS  = 4'd4;
    localparam logic [3:0] CFG_DIST_AT_BIN0  = 4'd5;
    localparam logic [3:0] CFG_INV_DIST_STEP = 4'd6;
    localparam logic [3:0] CFG_CURVE_POINTS  = 4'd7;

    // Register reset values (Q16.16).
    localparam logic [31:0] RST_MIN_LEVEL     = 32'hFC18_0000;
    localparam logic [31:0] RST_VEL_STEP      = 32'h0001_0000;
    localparam logic [31:0] RST_SUN_TERM_SIN  = 32'h000A_0000;
    localparam logic [31:0] RST_INV_DIST_STEP = 32'h0001_0000;

    // Fixed constants of the rotation model (Q16.16).
    localparam logic [63:0] BASE_RATE  = 64'd1638400;
    localparam logic [34:0] SUN_RADIUS = 35'd655360;

    // Saturation limits of a bin sum.
    localparam logic [47:0] SUM_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] SUM_MIN = 48'h8000_0000_0000;

endpackage

// ===== rtl/rotation_curve_distance_binner.sv =====
// Load request: a 64-step divider pass and a table write. Read request: the bin memories are read
// in S_RD_ISSUE, the result is registered in S_RD_OUT once the result side is free. Sample request:
// 2 divider passes of 64 steps, a search reading and checking each curve entry in turn, a 32-step
// square root, then distance, bin and accumulation; one request is in work at once. Synchronous
// active-low reset loads the control and configuration reset values, then a clearing pass zeroes
// all NUM_BINS bins while o_stall stays high. Configuration writes are taken in every cycle.
module rotation_curve_distance_binner
    import rcdb_pkg::*;
#(
    parameter int CURVE_DEPTH = 128,
    parameter int NUM_BINS    = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_action,
    input  logic [9:0]         i_slot,
    input  logic [11:0]        i_column,
    input  logic signed [31:0] i_sample_value,
    input  logic [30:0]        i_curve_radius,
    input  logic signed [31:0] i_curve_speed,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [47:0] o_bin_sum,
    output logic [31:0]        o_bin_count,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int CUR_W = $clog2(CURVE_DEPTH);
    localparam int CNT_W = $clog2(CURVE_DEPTH + 1);
    localparam int BIN_W = $clog2(NUM_BINS);

    localparam logic [4:0] S_CLEAR    = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_LD_DIV   = 5'd2;
    localparam logic [4:0] S_LD_WR    = 5'd3;
    localparam logic [4:0] S_SM_V     = 5'd4;
    localparam logic [4:0] S_SM_DST   = 5'd5;
    localparam logic [4:0] S_SM_DIV   = 5'd6;
    localparam logic [4:0] S_SM_RATE  = 5'd7;
    localparam logic [4:0] S_SRCH_RD  = 5'd8;
    localparam logic [4:0] S_SRCH_CHK = 5'd9;
    localparam logic [4:0] S_IP_MUL   = 5'd10;
    localparam logic [4:0] S_IP_DIV   = 5'd11;
    localparam logic [4:0] S_IP_RAD   = 5'd12;
    localparam logic [4:0] S_SQ_RS    = 5'd13;
    localparam logic [4:0] S_SQ_RR    = 5'd14;
    localparam logic [4:0] S_SQ_SUB   = 5'd15;
    localparam logic [4:0] S_SQRT     = 5'd16;
    localparam logic [4:0] S_DIST     = 5'd17;
    localparam logic [4:0] S_BIN_MUL  = 5'd18;
    localparam logic [4:0] S_BIN_CHK  = 5'd19;
    localparam logic [4:0] S_ACC_RD   = 5'd20;
    localparam logic [4:0] S_ACC_WR   = 5'd21;
    localparam logic [4:0] S_RD_ISSUE = 5'd22;
    localparam logic [4:0] S_RD_OUT   = 5'd23;

    // Control and configuration registers.
    logic [4:0]  r_state, n_state;
    logic [BIN_W-1:0] r_clr_idx;
    logic        r_out_valid;
    logic [31:0] r_min_level, r_vel0, r_vstep, r_rs, r_rc, r_dist0, r_inv;
    logic [7:0]  r_npts;

    // Request payload.
    t_action     r_act;
    logic [9:0]  r_slot;
    logic [11:0] r_col;
    logic [31:0] r_val;
    logic [30:0] r_rad;

    // Datapath registers.
    logic [44:0] r_v;
    logic [31:0] r_dv_rem, r_dv_div;
    logic [63:0] r_dv_quo;
    logic [5:0]  r_dv_cnt;
    logic        r_dv_neg;
    logic [63:0] r_wr;
    logic [CNT_W-1:0] r_n, r_ncurve;
    logic [31:0] r_rad_q, r_rate_q, r_prev_rad, r_prev_rate;
    logic [31:0] r_ia, r_den, r_cur_rad;
    logic [32:0] r_ird;
    logic [34:0] r_r;
    logic [63:0] r_rsq, r_rr;
    logic [63:0] r_sq_v;
    logic [35:0] r_sq_rem;
    logic [31:0] r_sq_root;
    logic [4:0]  r_sq_cnt;
    logic [35:0] r_d;
    logic [63:0] r_bprod;
    logic        r_bneg;
    logic [BIN_W-1:0] r_bin;
    logic [47:0] r_sum_q, r_out_sum;
    logic [31:0] r_cnt_q, r_out_cnt;

    // Memories.
    logic [31:0] curve_rad_mem  [CURVE_DEPTH];
    logic [31:0] curve_rate_mem [CURVE_DEPTH];
    logic [47:0] bin_sum_mem    [NUM_BINS];
    logic [31:0] bin_cnt_mem    [NUM_BINS];

    logic        in_acc, out_free;
    logic [31:0] slot_ext, rs_abs, ld_div, ld_rate;
    logic        slot_in_curve, slot_in_bins, smp_pass;
    logic [32:0] dv_t;
    logic        dv_ge, dv_last;
    logic [44:0] v_mag;
    logic [63:0] rate_ext, srch_diff;
    logic        srch_more, srch_end, den_ok;
    logic [32:0] ip_den, ird_mag;
    logic [64:0] ip_prod;
    logic [34:0] ip_q;
    logic        r_ok;
    logic [35:0] sq_rem2, sq_trial;
    logic        sq_ge, sq_last;
    logic [35:0] d_sum, d_mag;
    logic [31:0] inv_abs, ymag;
    logic        bin_ok, clr_last;
    logic [48:0] acc_sum;
    logic [47:0] acc_sat;
    logic [BIN_W-1:0] bin_waddr, bin_raddr;
    logic        bin_we;
    logic [47:0] bin_wsum;
    logic [31:0] bin_wcnt;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_bin_sum   = r_out_sum;
    assign o_bin_count = r_out_cnt;
    assign in_acc      = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;

    // Address and range checks.
    assign slot_ext      = {22'd0, r_slot};
    assign slot_in_curve = slot_ext < 32'(CURVE_DEPTH);
    assign slot_in_bins  = slot_ext < 32'(NUM_BINS);
    assign rs_abs        = r_rs[31] ? (32'd0 - r_rs) : r_rs;
    assign smp_pass      = ($signed(i_sample_value) > $signed(r_min_level)) && (r_rs != 32'd0);
    assign clr_last      = r_clr_idx == BIN_W'(NUM_BINS - 1);

    // Restoring divider step, one quotient bit per cycle.
    assign dv_t    = {r_dv_rem, r_dv_quo[63]};
    assign dv_ge   = dv_t >= {1'b0, r_dv_div};
    assign dv_last = r_dv_cnt == 6'd63;

    // Load: divisor and saturated rate.
    assign ld_div  = (i_curve_radius == 31'd0) ? 32'd1 : {1'b0, i_curve_radius};
    assign ld_rate = !r_dv_neg ? ((r_dv_quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r_dv_quo[31:0])
                               : ((r_dv_quo > 64'h8000_0000) ? 32'h8000_0000
                                                             : (32'd0 - r_dv_quo[31:0]));

    assign v_mag = r_v[44] ? (45'd0 - r_v) : r_v;

    // Table search.
    assign rate_ext  = {{32{r_rate_q[31]}}, r_rate_q};
    assign srch_more = $signed(r_wr) < $signed(rate_ext);
    assign srch_diff = r_wr - rate_ext;
    assign srch_end  = r_n == r_ncurve;
    assign ip_den    = {r_prev_rate[31], r_prev_rate} - {r_rate_q[31], r_rate_q};
    assign den_ok    = !ip_den[32] && (ip_den != 33'd0);

    // Interpolation.
    assign ird_mag = r_ird[32] ? (33'd0 - r_ird) : r_ird;
    assign ip_prod = 65'(r_ia) * 65'(ird_mag);
    assign ip_q    = r_dv_neg ? (35'd0 - r_dv_quo[34:0]) : r_dv_quo[34:0];
    assign r_ok    = $signed(r_r) >= $signed({3'd0, rs_abs});

    // Square root step, two radicand bits per cycle.
    assign sq_rem2  = {r_sq_rem[33:0], r_sq_v[63:62]};
    assign sq_trial = {2'd0, r_sq_root, 2'b01};
    assign sq_ge    = sq_rem2 >= sq_trial;
    assign sq_last  = r_sq_cnt == 5'd31;

    // Distance and bin.
    assign d_sum   = ($signed(r_r) < $signed(SUN_RADIUS))
                   ? ({{4{r_rc[31]}}, r_rc} - {4'd0, r_sq_root} - {{4{r_dist0[31]}}, r_dist0})
                   : ({{4{r_rc[31]}}, r_rc} + {4'd0, r_sq_root} - {{4{r_dist0[31]}}, r_dist0});
    assign d_mag   = r_d[35] ? (36'd0 - r_d) : r_d;
    assign inv_abs = r_inv[31] ? (32'd0 - r_inv) : r_inv;
    assign ymag    = r_bprod[63:32];
    assign bin_ok  = !(r_bneg && (ymag != 32'd0)) && (ymag < 32'(NUM_BINS));

    // Saturating accumulation.
    assign acc_sum = {r_sum_q[47], r_sum_q} + {{17{r_val[31]}}, r_val};
    assign acc_sat = (acc_sum[48] != acc_sum[47]) ? (acc_sum[48] ? SUM_MIN : SUM_MAX)
                                                  : acc_sum[47:0];

    // Bin memory port selection.
    assign bin_we    = (r_state == S_CLEAR) || (r_state == S_ACC_WR);
    assign bin_waddr = (r_state == S_CLEAR) ? r_clr_idx : r_bin;
    assign bin_wsum  = (r_state == S_CLEAR) ? 48'd0 : acc_sat;
    assign bin_wcnt  = (r_state == S_CLEAR) ? 32'd0
                     : ((r_cnt_q == 32'hFFFF_FFFF) ? r_cnt_q : r_cnt_q + 32'd1);
    assign bin_raddr = (r_state == S_ACC_RD) ? r_bin : slot_ext[BIN_W-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:    if (clr_last) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc) begin
                    case (i_action)
                        ACT_LOAD:   n_state = S_LD_DIV;
                        ACT_SAMPLE: n_state = smp_pass ? S_SM_V : S_IDLE;
                        ACT_READ:   n_state = S_RD_ISSUE;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_LD_DIV:   if (dv_last) n_state = S_LD_WR;
            S_LD_WR:    n_state = S_IDLE;
            S_SM_V:     n_state = S_SM_DST;
            S_SM_DST:   n_state = S_SM_DIV;
            S_SM_DIV:   if (dv_last) n_state = S_SM_RATE;
            S_SM_RATE:  n_state = S_SRCH_RD;
            S_SRCH_RD:  n_state = srch_end ? S_IDLE : S_SRCH_CHK;
            S_SRCH_CHK: begin
                if (srch_more) begin
                    n_state = S_SRCH_RD;
                end else if ((r_n == '0) || !den_ok) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_IP_MUL;
                end
            end
            S_IP_MUL:   n_state = S_IP_DIV;
            S_IP_DIV:   if (dv_last) n_state = S_IP_RAD;
            S_IP_RAD:   n_state = S_SQ_RS;
            S_SQ_RS:    n_state = r_ok ? S_SQ_RR : S_IDLE;
            S_SQ_RR:    n_state = S_SQ_SUB;
            S_SQ_SUB:   n_state = S_SQRT;
            S_SQRT:     if (sq_last) n_state = S_DIST;
            S_DIST:     n_state = S_BIN_MUL;
            S_BIN_MUL:  n_state = S_BIN_CHK;
            S_BIN_CHK:  n_state = bin_ok ? S_ACC_RD : S_IDLE;
            S_ACC_RD:   n_state = S_ACC_WR;
            S_ACC_WR:   n_state = S_IDLE;
            S_RD_ISSUE: n_state = S_RD_OUT;
            S_RD_OUT:   if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Control state, output valid and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            r_min_level <= RST_MIN_LEVEL;
            r_vel0      <= 32'd0;
            r_vstep     <= RST_VEL_STEP;
            r_rs        <= RST_SUN_TERM_SIN;
            r_rc        <= 32'd0;
            r_dist0     <= 32'd0;
            r_inv       <= RST_INV_DIST_STEP;
            r_npts      <= 8'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + BIN_W'(1);
            end
            if ((r_state == S_RD_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MIN_LEVEL:     r_min_level <= i_cfg_data;
                    CFG_VEL_AT_COL0:   r_vel0      <= i_cfg_data;
                    CFG_VEL_STEP:      r_vstep     <= i_cfg_data;
                    CFG_SUN_TERM_SIN:  r_rs        <= i_cfg_data;
                    CFG_SUN_TERM_COS:  r_rc        <= i_cfg_data;
                    CFG_DIST_AT_BIN0:  r_dist0     <= i_cfg_data;
                    CFG_INV_DIST_STEP: r_inv       <= i_cfg_data;
                    CFG_CURVE_POINTS:  r_npts      <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath sequencing.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_act    <= i_action;
                    r_slot   <= i_slot;
                    r_col    <= i_column;
                    r_val    <= i_sample_value;
                    r_rad    <= i_curve_radius;
                    r_dv_quo <= {16'd0, (i_curve_speed[31] ? (32'd0 - i_curve_speed)
                                                           : i_curve_speed), 16'd0};
                    r_dv_div <= ld_div;
                    r_dv_neg <= i_curve_speed[31];
                    r_dv_rem <= 32'd0;
                    r_dv_cnt <= 6'd0;
                end
            end
            S_LD_DIV, S_SM_DIV, S_IP_DIV: begin
                r_dv_rem <= dv_ge ? 32'(dv_t - {1'b0, r_dv_div}) : dv_t[31:0];
                r_dv_quo <= {r_dv_quo[62:0], dv_ge};
                r_dv_cnt <= r_dv_cnt + 6'd1;
            end
            S_SM_V: begin
                r_v <= 45'($signed({1'b0, r_col}) * $signed(r_vstep)) + {{13{r_vel0[31]}}, r_vel0};
            end
            S_SM_DST: begin
                r_dv_quo <= {3'd0, v_mag, 16'd0};
                r_dv_div <= rs_abs;
                r_dv_neg <= r_v[44] ^ r_rs[31];
                r_dv_rem <= 32'd0;
                r_dv_cnt <= 6'd0;
            end
            S_SM_RATE: begin
                r_wr     <= (r_dv_neg ? (64'd0 - r_dv_quo) : r_dv_quo) + BASE_RATE;
                r_n      <= '0;
                r_ncurve <= (32'(r_npts) > 32'(CURVE_DEPTH)) ? CNT_W'(CURVE_DEPTH)
                                                              : CNT_W'(r_npts);
            end
            S_SRCH_CHK: begin
                if (srch_more) begin
                    r_prev_rad  <= r_rad_q;
                    r_prev_rate <= r_rate_q;
                    r_n         <= r_n + CNT_W'(1);
                end else begin
                    r_ia      <= srch_diff[31:0];
                    r_ird     <= {1'b0, r_prev_rad} - {1'b0, r_rad_q};
                    r_den     <= ip_den[31:0];
                    r_cur_rad <= r_rad_q;
                end
            end
            S_IP_MUL: begin
                r_dv_quo <= ip_prod[63:0];
                r_dv_div <= r_den;
                r_dv_neg <= r_ird[32];
                r_dv_rem <= 32'd0;
                r_dv_cnt <= 6'd0;
            end
            S_IP_RAD: r_r <= ip_q + {3'd0, r_cur_rad};
            S_SQ_RS:  r_rsq <= 64'(rs_abs) * 64'(rs_abs);
            S_SQ_RR:  r_rr <= 64'(r_r[31:0]) * 64'(r_r[31:0]);
            S_SQ_SUB: begin
                r_sq_v    <= r_rr - r_rsq;
                r_sq_rem  <= 36'd0;
                r_sq_root <= 32'd0;
                r_sq_cnt  <= 5'd0;
            end
            S_SQRT: begin
                r_sq_rem  <= sq_ge ? (sq_rem2 - sq_trial) : sq_rem2;
                r_sq_root <= {r_sq_root[30:0], sq_ge};
                r_sq_v    <= {r_sq_v[61:0], 2'b00};
                r_sq_cnt  <= r_sq_cnt + 5'd1;
            end
            S_DIST: r_d <= d_sum;
            S_BIN_MUL: begin
                r_bprod <= 64'(d_mag) * 64'(inv_abs);
                r_bneg  <= r_d[35] ^ r_inv[31];
            end
            S_BIN_CHK: r_bin <= ymag[BIN_W-1:0];
            S_RD_OUT: begin
                if (out_free) begin
                    r_out_sum <= slot_in_bins ? r_sum_q : 48'd0;
                    r_out_cnt <= slot_in_bins ? r_cnt_q : 32'd0;
                end
            end
            default: ;
        endcase
    end

    // Curve table memories: written on load, read during the search.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_LD_WR) && slot_in_curve && (r_act == ACT_LOAD)) begin
            curve_rad_mem[slot_ext[CUR_W-1:0]]  <= {1'b0, r_rad};
            curve_rate_mem[slot_ext[CUR_W-1:0]] <= ld_rate;
        end
        r_rad_q  <= curve_rad_mem[r_n[CUR_W-1:0]];
        r_rate_q <= curve_rate_mem[r_n[CUR_W-1:0]];
    end

    // Bin memories: cleared after reset, read-modify-write per sample.
    always_ff @(posedge i_clk) begin
        if (bin_we) begin
            bin_sum_mem[bin_waddr] <= bin_wsum;
            bin_cnt_mem[bin_waddr] <= bin_wcnt;
        end
        r_sum_q <= bin_sum_mem[bin_raddr];
        r_cnt_q <= bin_cnt_mem[bin_raddr];
    end

endmodule

// ===== rtl/rcdb_checker.sv =====
// Port-level checker of the rotation-curve distance binner and its bind.
module rcdb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [47:0] o_bin_sum,
    input logic [31:0] o_bin_count,
    input logic        o_cfg_ready
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_bin_sum) && $stable(o_bin_count))
        else $error("result changed while stalled");

    // The clearing pass holds off requests right after reset.
    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_stall)
        else $error("request side open during clearing pass");

    // A new result appears only while a read request is in work.
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without a request in work");

endmodule

bind rotation_curve_distance_binner rcdb_checker u_rcdb_checker (.*);

// ===== bench/rotation_curve_distance_binner_tb.sv =====
// Self-checking testbench of the rotation-curve distance binner.
module rotation_curve_distance_binner_tb;
    import rcdb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int      CURVE_DEPTH = 128;
    localparam int      NUM_BINS    = 1024;
    localparam int      IDLE_LIMIT  = 20000;
    localparam int      SETTLE      = 700;
    localparam t_action ACT_NONE    = 2'd3;
    localparam longint  Q_ONE       = 65536;
    localparam longint  SAT_HI      = 64'sd140737488355327;
    localparam longint  SAT_LO      = -64'sd140737488355328;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_action = '0;
    logic [9:0]         i_slot = '0;
    logic [11:0]        i_column = '0;
    logic signed [31:0] i_sample_value = '0;
    logic [30:0]        i_curve_radius = '0;
    logic signed [31:0] i_curve_speed = '0;
    logic               o_valid;
    logic               i_stall = 1'b1;
    logic signed [47:0] o_bin_sum;
    logic [31:0]        o_bin_count;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [3:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    rotation_curve_distance_binner #(
        .CURVE_DEPTH(CURVE_DEPTH),
        .NUM_BINS(NUM_BINS)
    ) i_dut (.*);

    always #2 i_clk = ~i_clk;

    // One bin read as it should come back.
    typedef struct {
        logic [47:0] sum;
        logic [31:0] count;
    } bin_read_t;

    // One row of the directed stimulus.
    typedef struct {
        logic [1:0]  act;
        logic [9:0]  slot;
        logic [11:0] col;
        logic [31:0] val;
        logic [30:0] rad;
        logic [31:0] spd;
        bit          typed;
        logic [47:0] sum;
        logic [31:0] count;
    } stim_row_t;

    bin_read_t    pending_reads[$];
    int           fail_count = 0;
    int           idle_cycles = 0;
    bit           no_idling = 1'b0;

    // Shadow of the block's registers and memories.
    logic signed [31:0] shadow_reg[8];
    longint             curve_radius_tab[CURVE_DEPTH];
    longint             curve_rate_tab[CURVE_DEPTH];
    longint             bin_sum_tab[NUM_BINS];
    int unsigned        bin_count_tab[NUM_BINS];

    // Directed requests, run with the reset register values (empty curve).
    stim_row_t directed_rows[14] = '{
        '{ACT_READ,   10'd0,    12'd0,    32'd0,        31'd0,          32'd0,        1, 48'd0, 32'd0},
        '{ACT_READ,   10'd1023, 12'd0,    32'd0,        31'd0,          32'd0,        1, 48'd0, 32'd0},
        '{ACT_READ,   10'd512,  12'd0,    32'd0,        31'd0,          32'd0,        1, 48'd0, 32'd0},
        '{ACT_NONE,   10'h3FF,  12'hFFF,  32'hFFFFFFFF, 31'h7FFFFFFF,   32'hFFFFFFFF, 0, 48'd0, 32'd0},
        '{ACT_SAMPLE, 10'h3FF,  12'hFFF,  32'h80000000, 31'h7FFFFFFF,   32'h80000000, 0, 48'd0, 32'd0},
        '{ACT_SAMPLE, 10'd0,    12'hFFF,  32'h7FFFFFFF, 31'd0,          32'd0,        0, 48'd0, 32'd0},
        '{ACT_SAMPLE, 10'd0,    12'd0,    32'hFC180000, 31'd0,          32'd0,        0, 48'd0, 32'd0},
        '{ACT_LOAD,   10'd1023, 12'd0,    32'd0,        31'h7FFFFFFF,   32'h7FFFFFFF, 0, 48'd0, 32'd0},
        '{ACT_LOAD,   10'd128,  12'd0,    32'd0,        31'd65536,      32'd65536,    0, 48'd0, 32'd0},
        '{ACT_LOAD,   10'd0,    12'd0,    32'd0,        31'd0,          32'd1,        0, 48'd0, 32'd0},
        '{ACT_LOAD,   10'd1,    12'd0,    32'd0,        31'd1,          32'h80000000, 0, 48'd0, 32'd0},
        '{ACT_LOAD,   10'd127,  12'd0,    32'd0,        31'h7FFFFFFF,   32'h80000000, 0, 48'd0, 32'd0},
        '{ACT_SAMPLE, 10'd0,    12'd100,  32'd0,        31'd0,          32'd0,        0, 48'd0, 32'd0},
        '{ACT_READ,   10'd0,    12'd0,    32'd0,        31'd0,          32'd0,        1, 48'd0, 32'd0}
    };

    // Prints one mismatch and counts it.
    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    // Integer square root, floor.
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Stores one curve point as radius and angular rate.
    function automatic void store_curve_point(input logic [9:0] slot, input logic [30:0] rad,
                                              input logic signed [31:0] spd);
        longint radius = longint'(rad);
        longint rate = (longint'(spd) * Q_ONE) / (radius == 0 ? 1 : radius);
        if (rate > 64'sd2147483647) rate = 64'sd2147483647;
        if (rate < -64'sd2147483648) rate = -64'sd2147483648;
        if (slot < CURVE_DEPTH) begin
            curve_radius_tab[slot] = radius;
            curve_rate_tab[slot] = rate;
        end
    endfunction

    // Works out the distance bin of one sample and adds the sample to it.
    function automatic void bin_sample(input logic [11:0] col, input logic signed [31:0] val);
        longint value = longint'(val);
        longint rs = longint'(shadow_reg[CFG_SUN_TERM_SIN]);
        longint rc = longint'(shadow_reg[CFG_SUN_TERM_COS]);
        longint d0 = longint'(shadow_reg[CFG_DIST_AT_BIN0]);
        longint inv = longint'(shadow_reg[CFG_INV_DIST_STEP]);
        int     ncurve = int'(shadow_reg[CFG_CURVE_POINTS][7:0]);
        longint vel, wr, den, r, rs_abs, d, diff, s;
        longint unsigned sq, dmag, imag, ymag;
        bit     neg;
        int     n;
        if (ncurve > CURVE_DEPTH) ncurve = CURVE_DEPTH;
        if (value <= longint'(shadow_reg[CFG_MIN_LEVEL]) || rs == 0) return;
        vel = longint'(shadow_reg[CFG_VEL_AT_COL0])
            + longint'({20'd0, col}) * longint'(shadow_reg[CFG_VEL_STEP]);
        wr = (vel * Q_ONE) / rs + 25 * Q_ONE;
        // Search the falling rate table for the first entry not above the rate.
        n = 0;
        while (n < ncurve && wr < curve_rate_tab[n]) n++;
        if (n == 0 || n == ncurve) return;
        den = curve_rate_tab[n-1] - curve_rate_tab[n];
        if (den <= 0) return;
        r = ((wr - curve_rate_tab[n]) * (curve_radius_tab[n-1] - curve_radius_tab[n])) / den
            + curve_radius_tab[n];
        rs_abs = rs < 0 ? -rs : rs;
        if (r < rs_abs) return;
        sq = floor_sqrt(longint'(r * r - rs * rs));
        // Near side inside the solar circle, far side outside it.
        d = (r < 10 * Q_ONE) ? rc - longint'(sq) : rc + longint'(sq);
        diff = d - d0;
        neg = (diff < 0) != (inv < 0);
        dmag = diff < 0 ? -diff : diff;
        imag = inv < 0 ? -inv : inv;
        ymag = (dmag * imag) >> 32;
        if (neg && ymag != 0) return;
        if (ymag >= NUM_BINS) return;
        s = bin_sum_tab[ymag] + value;
        if (s > SAT_HI) s = SAT_HI;
        if (s < SAT_LO) s = SAT_LO;
        bin_sum_tab[ymag] = s;
        if (bin_count_tab[ymag] != 32'hFFFF_FFFF) bin_count_tab[ymag]++;
    endfunction

    // Sends one request, waits for its acceptance and updates the shadow state.
    task automatic send_request(input logic [1:0] act, input logic [9:0] slot,
                                input logic [11:0] col, input logic [31:0] val,
                                input logic [30:0] rad, input logic [31:0] spd,
                                input bit typed = 0, input logic [47:0] tsum = '0,
                                input logic [31:0] tcount = '0);
        int        gap;
        bin_read_t exp_read;
        gap = no_idling ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action = act;
        i_slot = slot;
        i_column = col;
        i_sample_value = val;
        i_curve_radius = rad;
        i_curve_speed = spd;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        case (act)
            ACT_LOAD:   store_curve_point(slot, rad, spd);
            ACT_SAMPLE: bin_sample(col, val);
            ACT_READ: begin
                exp_read.sum = bin_sum_tab[slot][47:0];
                exp_read.count = bin_count_tab[slot];
                if (typed) begin
                    exp_read.sum = tsum;
                    exp_read.count = tcount;
                end
                pending_reads.push_back(exp_read);
            end
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Drops the request valid and waits until all reads have returned and the block is idle.
    task automatic drain_block();
        i_valid = 1'b0;
        while (pending_reads.size() > 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Writes one configuration register.
    task automatic write_register(input logic [3:0] idx, input logic [31:0] data);
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        shadow_reg[idx] = data;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Writes a whole register setting, in index order.
    task automatic write_setting(input logic [31:0] lvl, input logic [31:0] v0,
                                 input logic [31:0] vs, input logic [31:0] sn,
                                 input logic [31:0] cs, input logic [31:0] d0,
                                 input logic [31:0] inv, input logic [7:0] npts);
        drain_block();
        write_register(CFG_MIN_LEVEL, lvl);
        write_register(CFG_VEL_AT_COL0, v0);
        write_register(CFG_VEL_STEP, vs);
        write_register(CFG_SUN_TERM_SIN, sn);
        write_register(CFG_SUN_TERM_COS, cs);
        write_register(CFG_DIST_AT_BIN0, d0);
        write_register(CFG_INV_DIST_STEP, inv);
        write_register(CFG_CURVE_POINTS, {24'd0, npts});
    endtask

    // Loads a smooth, strictly falling rotation curve into one table entry.
    task automatic load_smooth_point(input int idx);
        send_request(ACT_LOAD, 10'(idx), 12'($urandom_range(0, 4095)), $urandom,
                     31'(Q_ONE + idx * 16384), 32'(220 * Q_ONE + $urandom_range(0, 1023)));
    endtask

    // Random requests: mostly samples and reads in the useful range, some noise.
    task automatic random_requests(input int count);
        int          pick;
        logic [31:0] val;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 3) == 0) val = $urandom;
            else val = 32'($urandom_range(0, 100 * Q_ONE)) - 32'(20 * Q_ONE);
            if (pick < 58) begin
                send_request(ACT_SAMPLE, 10'($urandom), 12'($urandom_range(0, 4095)), val,
                             31'($urandom), $urandom);
            end else if (pick < 88) begin
                send_request(ACT_READ,
                             ($urandom_range(0, 4) == 0) ? 10'($urandom) :
                             10'($urandom_range(0, 600)),
                             12'($urandom), $urandom, 31'($urandom), $urandom);
            end else if (pick < 94) begin
                load_smooth_point($urandom_range(0, CURVE_DEPTH - 1));
            end else if (pick < 97) begin
                send_request(ACT_LOAD, 10'($urandom), 12'($urandom), $urandom,
                             31'($urandom), $urandom);
            end else begin
                send_request(ACT_NONE, 10'($urandom), 12'($urandom), $urandom,
                             31'($urandom), $urandom);
            end
        end
    endtask

    // Result side: random stall before each result, checked at the rising edge.
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) i_stall = (stall_left > 0);
    end

    always @(posedge i_clk) begin
        bin_read_t exp_read;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (pending_reads.size() == 0) begin
                report_mismatch("bin read result with no read request waiting");
            end else begin
                exp_read = pending_reads.pop_front();
                if (o_bin_sum !== exp_read.sum)
                    report_mismatch($sformatf("bin_sum %h, expected %h",
                                              o_bin_sum, exp_read.sum));
                if (o_bin_count !== exp_read.count)
                    report_mismatch($sformatf("bin_count %h, expected %h",
                                              o_bin_count, exp_read.count));
            end
            stall_left = no_idling ? 0 : $urandom_range(0, 7);
        end else if (stall_left > 0) begin
            stall_left--;
        end
    end

    // Watchdog on cycles with no handshake on any channel.
    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)
                || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            idle_cycles = 0;
        end else if (++idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Main sequence.
    initial begin
        shadow_reg[CFG_MIN_LEVEL] = RST_MIN_LEVEL;
        shadow_reg[CFG_VEL_AT_COL0] = '0;
        shadow_reg[CFG_VEL_STEP] = RST_VEL_STEP;
        shadow_reg[CFG_SUN_TERM_SIN] = RST_SUN_TERM_SIN;
        shadow_reg[CFG_SUN_TERM_COS] = '0;
        shadow_reg[CFG_DIST_AT_BIN0] = '0;
        shadow_reg[CFG_INV_DIST_STEP] = RST_INV_DIST_STEP;
        shadow_reg[CFG_CURVE_POINTS] = '0;
        for (int k = 0; k < NUM_BINS; k++) begin
            bin_sum_tab[k] = 0;
            bin_count_tab[k] = 0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part with the reset register values.
        foreach (directed_rows[k])
            send_request(directed_rows[k].act, directed_rows[k].slot, directed_rows[k].col,
                         directed_rows[k].val, directed_rows[k].rad, directed_rows[k].spd,
                         directed_rows[k].typed, directed_rows[k].sum, directed_rows[k].count);

        // Fill the whole curve table before any sample can search it.
        for (int k = 0; k < CURVE_DEPTH; k++) load_smooth_point(k);

        // Inner galaxy view: velocity -200 km/s up in steps of 0.1, 10 bins per kpc.
        write_setting(32'd0, -32'(200 * Q_ONE), 32'd6554, 32'(8 * Q_ONE), 32'(5 * Q_ONE),
                      -32'(2 * Q_ONE), 32'(10 * Q_ONE), 8'd128);
        random_requests(170);
        drain_block();
        random_requests(170);

        // Mirrored view with negative sine and bin step, no idling on either side.
        no_idling = 1'b1;
        write_setting(32'h8000_0000, 32'(200 * Q_ONE), -32'd6554, -32'(8 * Q_ONE),
                      -32'(3 * Q_ONE), 32'(40 * Q_ONE), -32'(10 * Q_ONE), 8'd255);
        random_requests(280);
        no_idling = 1'b0;

        // Register extremes: every sample is dropped.
        write_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'd1);
        random_requests(70);

        // Zero sine term and a two-point curve.
        write_setting(32'hFFFF_FFFF, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0,
                      32'h0001_0000, 8'd2);
        random_requests(70);

        // Restore the curve, then a half-length table with a low threshold.
        for (int k = 0; k < CURVE_DEPTH; k++) load_smooth_point(k);
        write_setting(32'h8000_0000, -32'(150 * Q_ONE), 32'd3277, 32'(6 * Q_ONE),
                      32'(8 * Q_ONE), -32'(4 * Q_ONE), 32'(8 * Q_ONE), 8'd64);
        random_requests(300);

        drain_block();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rcdb_pkg.sv
rtl/rotation_curve_distance_binner.sv
rtl/rcdb_checker.sv
bench/rotation_curve_distance_binner_tb.sv
